// ----- design/cfwk_pkg.sv -----
// Shared constants, types and helpers for the circular FIFO with walk.
`timescale 1ns / 1ps

package cfwk_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 32;

    localparam logic [1:0] OP_ENQ     = 2'd0;
    localparam logic [1:0] OP_DEQ     = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_DISPLAY = 2'd3;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_WORD     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_WALK
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit_ram;
        logic emit_last;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic is_empty;
        logic walk_final;
        logic out_free;
    } stat_t;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
        logic [ADDR_W-1:0] r;
        if (i == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- design/cfwk_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cfwk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/cfwk_ctrl.sv -----
// Controller state machine: sequences accepts, single reads and the display walk.
`timescale 1ns / 1ps

module cfwk_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic [1:0]     op,
    output logic           s_tready,
    input  cfwk_pkg::stat_t stat,
    output cfwk_pkg::cmd_t  cmd
);

    cfwk_pkg::state_t state_reg;
    cfwk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfwk_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfwk_pkg::S_IDLE:
            begin
                if (s_tvalid && stat.out_free && op != cfwk_pkg::OP_ENQ && !stat.is_empty)
                begin
                    if (op == cfwk_pkg::OP_DISPLAY)
                    begin
                        state_next = cfwk_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = cfwk_pkg::S_SINGLE;
                    end
                end
            end
            cfwk_pkg::S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    state_next = cfwk_pkg::S_IDLE;
                end
            end
            cfwk_pkg::S_WALK:
            begin
                if (stat.out_free && stat.walk_final)
                begin
                    state_next = cfwk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfwk_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.emit_ram  = 1'b0;
        cmd.emit_last = 1'b0;
        cmd.advance   = 1'b0;
        unique case (state_reg)
            cfwk_pkg::S_IDLE:
            begin
                s_tready   = stat.out_free;
                cmd.accept = s_tvalid && stat.out_free;
            end
            cfwk_pkg::S_SINGLE:
            begin
                cmd.emit_ram  = stat.out_free;
                cmd.emit_last = 1'b1;
            end
            cfwk_pkg::S_WALK:
            begin
                cmd.emit_ram  = stat.out_free;
                cmd.emit_last = stat.walk_final;
                cmd.advance   = stat.out_free && !stat.walk_final;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/cfwk_dp.sv -----
// Datapath: queue pointers, word store, walk pointer and the output register.
`timescale 1ns / 1ps

module cfwk_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    op,
    input  logic [cfwk_pkg::WORD_W-1:0]   value,
    input  cfwk_pkg::cmd_t                cmd,
    output cfwk_pkg::stat_t               stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cfwk_pkg::WORD_W-1:0]   m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    logic [cfwk_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [cfwk_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [cfwk_pkg::ADDR_W-1:0] walk_reg, walk_next;
    logic                        empty_reg, empty_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [cfwk_pkg::WORD_W-1:0] word_reg, word_next;
    logic                        last_reg, last_next;
    logic                        load_out;

    logic                        full;
    logic                        is_enq;
    logic                        wr_en;
    logic [cfwk_pkg::ADDR_W-1:0] wr_addr;
    logic [cfwk_pkg::WORD_W-1:0] rd_data;

    assign full   = (cfwk_pkg::next_slot(tail_reg) == head_reg) && !empty_reg;
    assign is_enq = (op == cfwk_pkg::OP_ENQ);

    assign wr_en   = cmd.accept && is_enq && !full;
    assign wr_addr = empty_reg ? '0 : cfwk_pkg::next_slot(tail_reg);

    assign stat.is_empty   = empty_reg;
    assign stat.walk_final = (walk_reg == tail_reg);
    assign stat.out_free   = !out_valid_reg || m_tready;

    // Pointer and queue state updates happen at accept time.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        if (cmd.accept)
        begin
            if (is_enq)
            begin
                if (empty_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                end
                else if (!full)
                begin
                    tail_next = cfwk_pkg::next_slot(tail_reg);
                end
            end
            else if (op == cfwk_pkg::OP_DEQ && !empty_reg)
            begin
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = cfwk_pkg::next_slot(head_reg);
                end
            end
        end
    end

    // The read address is the walk pointer's next value, so the registered read data
    // lines up with the walk pointer register.
    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.accept)
        begin
            walk_next = head_reg;
        end
        else if (cmd.advance)
        begin
            walk_next = cfwk_pkg::next_slot(walk_reg);
        end
    end

    always_comb
    begin
        status_next    = status_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        load_out       = 1'b0;
        if (cmd.accept && (is_enq || empty_reg))
        begin
            load_out       = 1'b1;
            out_valid_next = 1'b1;
            word_next      = '0;
            last_next      = 1'b1;
            if (!is_enq)
            begin
                status_next = cfwk_pkg::ST_EMPTY;
            end
            else if (full)
            begin
                status_next = cfwk_pkg::ST_FULL;
            end
            else
            begin
                status_next = cfwk_pkg::ST_ENQUEUED;
            end
        end
        else if (cmd.emit_ram)
        begin
            load_out       = 1'b1;
            out_valid_next = 1'b1;
            status_next    = cfwk_pkg::ST_WORD;
            word_next      = rd_data;
            last_next      = cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            walk_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            walk_reg      <= walk_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= status_next;
            word_reg   <= word_next;
            last_reg   <= last_next;
        end
    end

    cfwk_ram #(
        .WIDTH (cfwk_pkg::WORD_W),
        .DEPTH (cfwk_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_addr (walk_next),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- design/circular_fifo_with_walk_core.sv -----
// Enqueue and empty-queue results go straight into the output register at accept time.
// Dequeue and peek results pass the store's registered read, then the output register.
// Enqueues go one per cycle while the output is free; dequeue, peek and display block new
// input until done; display sends one word per cycle from the walk pointer, stalls aside.
// Reset (rst_n low, asynchronous) empties the queue and clears both indices;
// the word store itself is not cleared and holds no valid word until written.
`timescale 1ns / 1ps

module circular_fifo_with_walk_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input transactions.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed word to enqueue)
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result transactions.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] word (signed, zero unless a word is returned)
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last result caused by one input transaction
);

    cfwk_pkg::cmd_t  cmd;
    cfwk_pkg::stat_t stat;

    // The controller decides when an input transaction is taken and steps the
    // datapath through the single read of dequeue and peek, or the walk of a
    // display. Results that need no stored word are written straight into the
    // output register at accept time.
    cfwk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds head, tail and the empty flag, the word store, the
    // walk pointer that addresses the store's read port, and the output
    // register that separates the input side from the result side.
    cfwk_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (s_tuser),
        .value    (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/circular_fifo_with_walk_core_test.sv -----
// Self-checking testbench for the circular FIFO with walk: directed table, then random traffic.
`timescale 1ns / 1ps

module circular_fifo_with_walk_core_test;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
        logic        last;
    } fifo_result_t;

    // One row of the directed table. When pinned is set, the row carries its own
    // single expected result (last is always 1 for those rows). Otherwise the
    // expected results come from the mirror of the queue kept below.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic        pinned;
        logic [1:0]  want_status;
        logic [31:0] want_word;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic [1:0]  s_tuser;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] word
    logic [1:0]  m_tuser;    // [1:0] status
    logic        m_tlast;

    // Mirror of the queue, updated at the edge where an input transaction is accepted.
    logic [31:0]                 mirror_mem [cfwk_pkg::DEPTH];
    logic [cfwk_pkg::ADDR_W-1:0] mirror_head;
    logic [cfwk_pkg::ADDR_W-1:0] mirror_tail;
    logic                        mirror_empty;

    // Results that one input transaction produces, filled by the mirror step.
    fifo_result_t step_results [$];
    // Results still owed by the block, oldest first.
    fifo_result_t awaited_results [$];

    stim_row_t directed_rows [DIRECTED_ROWS];

    int mismatch_count = 0;
    // Remaining transactions of a stretch with no idling, one counter per side.
    int sender_calm = 0;
    int receiver_calm = 0;

    circular_fifo_with_walk_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [cfwk_pkg::ADDR_W-1:0] wrap_inc(
        input logic [cfwk_pkg::ADDR_W-1:0] slot);
        return cfwk_pkg::ADDR_W'((int'(slot) + 1) % cfwk_pkg::DEPTH);
    endfunction

    // Number of words the mirror holds.
    function automatic int mirror_count();
        if (mirror_empty)
        begin
            return 0;
        end
        return ((int'(mirror_tail) - int'(mirror_head) + cfwk_pkg::DEPTH) % cfwk_pkg::DEPTH)
               + 1;
    endfunction

    // Idle cycles before the next transaction on one side. Most draws give a random gap,
    // but now and then a run of back-to-back transactions starts.
    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Random word with a bias toward the extremes of the signed range.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Weighted operation choice, weights in percent; display takes what is left.
    function automatic logic [1:0] pick_op(input int enq_pct, input int deq_pct,
                                           input int peek_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
        begin
            return cfwk_pkg::OP_ENQ;
        end
        if (r < enq_pct + deq_pct)
        begin
            return cfwk_pkg::OP_DEQ;
        end
        if (r < enq_pct + deq_pct + peek_pct)
        begin
            return cfwk_pkg::OP_PEEK;
        end
        return cfwk_pkg::OP_DISPLAY;
    endfunction

    // Apply one operation to the mirror and collect the results it must produce.
    task automatic track_fifo_op(input logic [1:0] op, input logic [31:0] value);
        logic [cfwk_pkg::ADDR_W-1:0] slot;
        logic                        at_tail;
        step_results.delete();
        if (op == cfwk_pkg::OP_ENQ)
        begin
            if (mirror_empty)
            begin
                // An empty queue restarts at slot 0.
                mirror_head   = '0;
                mirror_tail   = '0;
                mirror_mem[0] = value;
                mirror_empty  = 1'b0;
                step_results.push_back('{cfwk_pkg::ST_ENQUEUED, 32'h0, 1'b1});
            end
            else if (wrap_inc(mirror_tail) == mirror_head)
            begin
                // Full: the word is dropped and nothing moves.
                step_results.push_back('{cfwk_pkg::ST_FULL, 32'h0, 1'b1});
            end
            else
            begin
                mirror_tail             = wrap_inc(mirror_tail);
                mirror_mem[mirror_tail] = value;
                step_results.push_back('{cfwk_pkg::ST_ENQUEUED, 32'h0, 1'b1});
            end
        end
        else if (mirror_empty)
        begin
            step_results.push_back('{cfwk_pkg::ST_EMPTY, 32'h0, 1'b1});
        end
        else if (op == cfwk_pkg::OP_DEQ)
        begin
            step_results.push_back('{cfwk_pkg::ST_WORD, mirror_mem[mirror_head], 1'b1});
            if (mirror_head == mirror_tail)
            begin
                // Taking the only word empties the queue and resets both indices.
                mirror_head  = '0;
                mirror_tail  = '0;
                mirror_empty = 1'b1;
            end
            else
            begin
                mirror_head = wrap_inc(mirror_head);
            end
        end
        else if (op == cfwk_pkg::OP_PEEK)
        begin
            step_results.push_back('{cfwk_pkg::ST_WORD, mirror_mem[mirror_head], 1'b1});
        end
        else
        begin
            // Display walks from the oldest word to the newest and flags the newest.
            slot = mirror_head;
            do
            begin
                at_tail = (slot == mirror_tail);
                step_results.push_back('{cfwk_pkg::ST_WORD, mirror_mem[slot], at_tail});
                slot = wrap_inc(slot);
            end
            while (!at_tail);
        end
    endtask

    // Present one input transaction, wait for it to be taken, and record what it owes.
    // s_tvalid gets at most one assignment per time step: it only drops when a gap
    // follows, and it is raised again at a later edge.
    task automatic send_op(input logic [1:0] op, input logic [31:0] value,
                           input logic pinned, input logic [1:0] want_status,
                           input logic [31:0] want_word);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        track_fifo_op(op, value);
        if (pinned)
        begin
            awaited_results.push_back('{want_status, want_word, 1'b1});
        end
        else
        begin
            foreach (step_results[k])
            begin
                awaited_results.push_back(step_results[k]);
            end
        end
    endtask

    // Directed part: empty-queue answers, the signed extremes, a multi-word display,
    // removal of the only word (indices back to slot 0), and value bits set on
    // operations that must ignore the value.
    initial
    begin
        directed_rows = '{
            '{cfwk_pkg::OP_DEQ,     32'hFFFF_FFFF, 1'b1, cfwk_pkg::ST_EMPTY,    32'h0},
            '{cfwk_pkg::OP_PEEK,    32'h8000_0000, 1'b1, cfwk_pkg::ST_EMPTY,    32'h0},
            '{cfwk_pkg::OP_DISPLAY, 32'h7FFF_FFFF, 1'b1, cfwk_pkg::ST_EMPTY,    32'h0},
            '{cfwk_pkg::OP_ENQ,     32'h8000_0000, 1'b1, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_PEEK,    32'h0000_0000, 1'b1, cfwk_pkg::ST_WORD,     32'h8000_0000},
            '{cfwk_pkg::OP_ENQ,     32'h7FFF_FFFF, 1'b1, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_ENQ,     32'hFFFF_FFFF, 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_ENQ,     32'h0000_0000, 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_ENQ,     32'h0000_0001, 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_DISPLAY, 32'h0000_0000, 1'b0, cfwk_pkg::ST_WORD,     32'h0},
            '{cfwk_pkg::OP_DEQ,     32'h1234_5678, 1'b1, cfwk_pkg::ST_WORD,     32'h8000_0000},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b1, cfwk_pkg::ST_WORD,     32'h7FFF_FFFF},
            '{cfwk_pkg::OP_PEEK,    32'hFFFF_FFFF, 1'b1, cfwk_pkg::ST_WORD,     32'hFFFF_FFFF},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b0, cfwk_pkg::ST_WORD,     32'h0},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b0, cfwk_pkg::ST_WORD,     32'h0},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b1, cfwk_pkg::ST_WORD,     32'h0000_0001},
            '{cfwk_pkg::OP_DEQ,     32'hAAAA_5555, 1'b1, cfwk_pkg::ST_EMPTY,    32'h0},
            '{cfwk_pkg::OP_ENQ,     32'hA5A5_A5A5, 1'b1, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_ENQ,     32'h5A5A_5A5A, 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0},
            '{cfwk_pkg::OP_DISPLAY, 32'hFFFF_FFFF, 1'b0, cfwk_pkg::ST_WORD,     32'h0},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b1, cfwk_pkg::ST_WORD,     32'hA5A5_A5A5},
            '{cfwk_pkg::OP_DEQ,     32'h0000_0000, 1'b1, cfwk_pkg::ST_WORD,     32'h5A5A_5A5A},
            '{cfwk_pkg::OP_DISPLAY, 32'h0000_0000, 1'b1, cfwk_pkg::ST_EMPTY,    32'h0}
        };
    end

    // Stimulus: reset, the directed table, then random traffic shaped to fill the
    // queue to the brim, overflow it, walk it full, and drain it back to empty.
    initial
    begin : stimulus
        int n;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= cfwk_pkg::OP_ENQ;
        mirror_head  = '0;
        mirror_tail  = '0;
        mirror_empty = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            send_op(directed_rows[r].op, directed_rows[r].value, directed_rows[r].pinned,
                    directed_rows[r].want_status, directed_rows[r].want_word);
        end

        // Mostly enqueues with some dequeues, so the indices wrap around the store.
        for (n = 0; n < 30; n++)
        begin
            send_op(pick_op(70, 12, 8), rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        end
        while (mirror_count() < cfwk_pkg::DEPTH)
        begin
            send_op(($urandom_range(0, 7) == 0) ? cfwk_pkg::OP_PEEK : cfwk_pkg::OP_ENQ,
                    rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        end
        // Overflow attempts on a full queue, then a walk of all DEPTH words.
        for (n = 0; n < 3; n++)
        begin
            send_op(cfwk_pkg::OP_ENQ, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        end
        send_op(cfwk_pkg::OP_DISPLAY, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);

        // Mixed traffic leaning toward removal.
        for (n = 0; n < 20; n++)
        begin
            send_op(pick_op(20, 55, 10), rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        end
        while (!mirror_empty)
        begin
            send_op(cfwk_pkg::OP_DEQ, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        end
        send_op(cfwk_pkg::OP_DEQ, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        send_op(cfwk_pkg::OP_PEEK, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        send_op(cfwk_pkg::OP_DISPLAY, rand_word(), 1'b0, cfwk_pkg::ST_ENQUEUED, 32'h0);
        s_tvalid <= 1'b0;

        // Let every owed result arrive, then watch a little longer for strays.
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: for every result transaction, hold tready low for a random gap, possibly none,
    // then raise it until the block delivers. One assignment per time step.
    initial
    begin : receiver
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = pick_gap(receiver_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
        end
    end

    // Checker: every accepted result transaction is matched field by field against
    // the oldest result still owed.
    always @(posedge clk)
    begin : result_check
        fifo_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d, word %h, last %0d",
                       m_tuser, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.word)
                begin
                    $error("word: expected %h, actual %h", want.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run, so only a hang ends up here.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- circular_fifo_with_walk_core.f -----
design/cfwk_pkg.sv
design/cfwk_ram.sv
design/cfwk_ctrl.sv
design/cfwk_dp.sv
design/circular_fifo_with_walk_core.sv
bench/circular_fifo_with_walk_core_test.sv
